FILE: rtl/core/generational_handle_table_defines.svh
// assertion macros for the generational handle table
// expects clk and rst_n in the scope where a macro is used
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ght_pkg.sv
// shared widths, codes and helpers for the generational handle table
// no dependencies
`timescale 1ns / 1ps

package ght_pkg;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int HIDX_W   = 6;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LCNT_W   = 7;
  localparam int VER_W    = 64;

  // default table size
  localparam int SLOT_COUNT_DEF = 64;

  // opcodes; the unused code behaves as a check
  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

  // generation step, wraps past zero to one
  function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  // version step, wraps past zero to one
  function automatic logic [VER_W-1:0] ver_advance(input logic [VER_W-1:0] v);
    logic [VER_W-1:0] n;
    n = v + VER_W'(1);
    return (n == '0) ? VER_W'(1) : n;
  endfunction

endpackage

FILE: rtl/core/generational_handle_table.sv
// generational handle table: slot map with index/generation handles
// depends on ght_pkg and generational_handle_table_defines.svh
`timescale 1ns / 1ps
`include "generational_handle_table_defines.svh"

// Usage
//   A command word (opcode, handle index, handle generation) is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result is produced. The result word sits on the out_ ports for one
//   cycle with out_valid high; the receiver must take it then, it cannot
//   stall. A new command may be issued in the cycle the result is shown.
//   Timing: a small sequencer drives one read port of the slot memory
//   (live flag and generation per slot), one entry per cycle.
//   Release and check: the slot is read as the command is taken, and the
//   result is decided in the look-up state. Allocate scans used slots from
//   index 0 one per cycle and stops at the lowest free one; past the last
//   used slot, or straight away on an empty table, it appends a new slot or
//   reports full. No new command is taken while busy is high.
//   Reset clears the live count, used-slot count and version at once; the
//   slot memory needs no clearing, entries at or above the used-slot count
//   are never trusted. There is no clearing pass after reset.
module generational_handle_table #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ght_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [ght_pkg::HIDX_W-1:0]   in_handle_index,
  input  logic [ght_pkg::GEN_W-1:0]    in_handle_generation,
  output logic                         out_valid,
  output logic [ght_pkg::STATUS_W-1:0] out_status,
  output logic [ght_pkg::HIDX_W-1:0]   out_slot_index,
  output logic [ght_pkg::GEN_W-1:0]    out_slot_generation,
  output logic                         out_is_live,
  output logic [ght_pkg::LCNT_W-1:0]   out_live_count,
  output logic [ght_pkg::VER_W-1:0]    out_table_version
);

  import ght_pkg::*;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_LOOK
  } state_t;

  // control state
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic [COUNT_W-1:0]   slots_used_r, slots_used_nxt;
  logic [COUNT_W-1:0]   live_total_r, live_total_nxt;
  logic [VER_W-1:0]     version_r, version_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // latched command word
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [HIDX_W-1:0]    idx_r, idx_nxt;
  logic [GEN_W-1:0]     gen_r, gen_nxt;

  // result registers
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [HIDX_W-1:0]    slot_r, slot_nxt;
  logic [GEN_W-1:0]     sgen_r, sgen_nxt;
  logic                 live_r, live_nxt;

  // slot memory: {live, generation}
  logic [GEN_W:0]       mem [SLOT_COUNT];
  logic [GEN_W:0]       rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [GEN_W:0]       wr_data;

  // index conversions between port width and table width
  logic [IDX_W+HIDX_W-1:0] in_idx_ext, reg_idx_ext;
  logic [IDX_W+HIDX_W-1:0] res_slot_ext;
  logic [IDX_W-1:0]        res_slot;
  logic [COUNT_W+LCNT_W-1:0] lcnt_ext;

  // memory read fields and helper compares
  logic                 rd_live;
  logic [GEN_W-1:0]     rd_gen;
  logic [GEN_W-1:0]     rd_gen_adv;
  logic                 scan_last;
  logic                 idx_in_range;
  logic                 handle_live;

  assign in_idx_ext  = {{IDX_W{1'b0}}, in_handle_index};
  assign reg_idx_ext = {{IDX_W{1'b0}}, idx_r};
  assign rd_live     = rd_data_r[GEN_W];
  assign rd_gen      = rd_data_r[GEN_W-1:0];
  assign rd_gen_adv  = gen_advance(rd_gen);
  assign scan_last   = ((COUNT_W+1)'(scan_r) + (COUNT_W+1)'(1)) == (COUNT_W+1)'(slots_used_r);
  assign idx_in_range = (COUNT_W+HIDX_W)'(idx_r) < (COUNT_W+HIDX_W)'(slots_used_r);
  assign handle_live = (gen_r != '0) && idx_in_range && rd_live && (rd_gen == gen_r);

  // sequencer next-state and result logic
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    slots_used_nxt = slots_used_r;
    live_total_nxt = live_total_r;
    version_nxt    = version_r;
    out_valid_nxt  = 1'b0;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    gen_nxt        = gen_r;
    status_nxt     = status_r;
    res_slot       = '0;
    sgen_nxt       = sgen_r;
    live_nxt       = live_r;
    rd_addr        = in_idx_ext[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = scan_r;
    wr_data        = '0;
    slot_nxt       = slot_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          idx_nxt = in_handle_index;
          gen_nxt = in_handle_generation;
          if (in_opcode == OP_ALLOC) begin
            scan_nxt = '0;
            rd_addr  = '0;
            state_nxt = (slots_used_r == '0) ? S_APPEND : S_SCAN;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end

      // walk used slots for the lowest one not live
      S_SCAN: begin
        if (!rd_live) begin
          wr_en          = 1'b1;
          wr_addr        = scan_r;
          wr_data        = {1'b1, rd_gen_adv};
          res_slot       = scan_r;
          slot_nxt       = res_slot_ext[HIDX_W-1:0];
          sgen_nxt       = rd_gen_adv;
          status_nxt     = ST_OK;
          live_nxt       = 1'b0;
          live_total_nxt = live_total_r + COUNT_W'(1);
          version_nxt    = ver_advance(version_r);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (scan_last) begin
          state_nxt = S_APPEND;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
          rd_addr  = scan_r + IDX_W'(1);
        end
      end

      // every used slot is live: append or report full
      S_APPEND: begin
        live_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (slots_used_r != COUNT_W'(SLOT_COUNT)) begin
          wr_en          = 1'b1;
          wr_addr        = slots_used_r[IDX_W-1:0];
          wr_data        = {1'b1, GEN_W'(1)};
          res_slot       = slots_used_r[IDX_W-1:0];
          slot_nxt       = res_slot_ext[HIDX_W-1:0];
          sgen_nxt       = GEN_W'(1);
          status_nxt     = ST_OK;
          slots_used_nxt = slots_used_r + COUNT_W'(1);
          live_total_nxt = live_total_r + COUNT_W'(1);
          version_nxt    = ver_advance(version_r);
        end else begin
          slot_nxt   = '0;
          sgen_nxt   = '0;
          status_nxt = ST_FULL;
        end
      end

      // release or check against the slot read for the handle
      S_LOOK: begin
        slot_nxt      = idx_r;
        sgen_nxt      = '0;
        live_nxt      = handle_live;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!handle_live) begin
          status_nxt = ST_STALE;
        end else begin
          status_nxt = ST_OK;
          if (op_r == OP_RELEASE) begin
            wr_en          = 1'b1;
            wr_addr        = reg_idx_ext[IDX_W-1:0];
            wr_data        = {1'b0, rd_gen_adv};
            live_total_nxt = live_total_r - COUNT_W'(1);
            version_nxt    = ver_advance(version_r);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_slot_ext = {{HIDX_W{1'b0}}, res_slot};
  assign lcnt_ext     = {{LCNT_W{1'b0}}, live_total_nxt};

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= '0;
      slots_used_r <= '0;
      live_total_r <= '0;
      version_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      slots_used_r <= slots_used_nxt;
      live_total_r <= live_total_nxt;
      version_r    <= version_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      idx_r        <= idx_nxt;
      gen_r        <= gen_nxt;
      status_r     <= status_nxt;
      slot_r       <= slot_nxt;
      sgen_r       <= sgen_nxt;
      live_r       <= live_nxt;
      if (out_valid_nxt) begin
        out_live_count    <= lcnt_ext[LCNT_W-1:0];
        out_table_version <= version_nxt;
      end
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_slot_index      = slot_r;
  assign out_slot_generation = sgen_r;
  assign out_is_live         = live_r;

  // checks on sequencer bookkeeping
  `GHT_ASSERT_IMP(a_live_le_used, 1'b1, live_total_r <= slots_used_r, "live count above used slots")
  `GHT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `GHT_ASSERT_IMP(a_full_all_live, out_valid && (out_status == ST_FULL), live_total_r == COUNT_W'(SLOT_COUNT), "full reported with a free slot")
  `GHT_ASSERT_IMP(a_alloc_gen_nz, out_valid && (op_r == OP_ALLOC) && (out_status == ST_OK), out_slot_generation != '0, "allocate gave generation zero")

endmodule
